>>> design/ptw_pkg.sv
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared widths, codes, word types and the entry address helper for the
// four-level page table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

    // table geometry
    localparam int LEVELS   = 4;
    localparam int ADDR_W   = 48;
    localparam int DESC_W   = 64;
    localparam int PEND_W   = ADDR_W + 1;
    localparam int LVL_W    = 2;
    localparam int PG_BITS  = 12;
    localparam int MAP_BITS = 9;
    localparam int ENT_BITS = 3;

    localparam logic [ADDR_W-1:0] BASE_MASK  = 48'hFFFF_FFFF_F000;
    localparam logic [ADDR_W-1:0] ROOT_RESET = ADDR_W'(1 << PG_BITS);
    localparam logic [PEND_W-1:0] PG_SIZE    = PEND_W'(1 << PG_BITS);
    localparam logic [LVL_W-1:0]  LVL_TOP    = LVL_W'(LEVELS - 1);
    localparam logic [LVL_W-1:0]  LVL_LAST   = '0;

    // request types
    localparam logic REQ_XLATE = 1'b0;
    localparam logic REQ_DESC  = 1'b1;

    // result kinds
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [ADDR_W-1:0] virt_addr;
        logic [DESC_W-1:0] descriptor;
    } t_req;

    typedef struct packed {
        logic              out_kind;
        logic [ADDR_W-1:0] read_addr;
        logic [ADDR_W-1:0] phys_addr;
        logic [PEND_W-1:0] page_end;
        logic              fault;
    } t_res;

    // address of the entry for one level: base plus nine index bits times eight
    function automatic logic [ADDR_W-1:0] entry_addr(
        input logic [ADDR_W-1:0] base,
        input logic [ADDR_W-1:0] va,
        input logic [LVL_W-1:0]  level
    );
        logic [MAP_BITS-1:0] idx;
        case (level)
            2'd0:    idx = va[PG_BITS                +: MAP_BITS];
            2'd1:    idx = va[PG_BITS + MAP_BITS     +: MAP_BITS];
            2'd2:    idx = va[PG_BITS + 2 * MAP_BITS +: MAP_BITS];
            default: idx = va[PG_BITS + 3 * MAP_BITS +: MAP_BITS];
        endcase
        return base + ADDR_W'({idx, {ENT_BITS{1'b0}}});
    endfunction

endpackage

>>> design/ptw_req_if.sv
// ----------------------------------------------------------------------------
// ptw_req_if
// Request channel: translate requests and descriptor responses.
// ----------------------------------------------------------------------------
interface ptw_req_if;
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic [ptw_pkg::ADDR_W-1:0]   virt_addr;
    logic [ptw_pkg::DESC_W-1:0]   descriptor;

    modport source (output valid, output req_type, output virt_addr,
                    output descriptor, input ready);
    modport sink   (input valid, input req_type, input virt_addr,
                    input descriptor, output ready);
endinterface

>>> design/ptw_res_if.sv
// ----------------------------------------------------------------------------
// ptw_res_if
// Result channel: descriptor read requests and finished translations.
// ----------------------------------------------------------------------------
interface ptw_res_if;
    logic                         valid;
    logic                         ready;
    logic                         out_kind;
    logic [ptw_pkg::ADDR_W-1:0]   read_addr;
    logic [ptw_pkg::ADDR_W-1:0]   phys_addr;
    logic [ptw_pkg::PEND_W-1:0]   page_end;
    logic                         fault;

    modport source (output valid, output out_kind, output read_addr,
                    output phys_addr, output page_end, output fault, input ready);
    modport sink   (input valid, input out_kind, input read_addr,
                    input phys_addr, input page_end, input fault, output ready);
endinterface

>>> design/ptw_cfg_if.sv
// ----------------------------------------------------------------------------
// ptw_cfg_if
// Configuration write channel for the root table address.
// ----------------------------------------------------------------------------
interface ptw_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [ptw_pkg::ADDR_W-1:0]   wdata;

    modport source (output valid, output wdata, input ready);
    modport sink   (input valid, input wdata, output ready);
endinterface

>>> design/ptw_core.sv
// ----------------------------------------------------------------------------
// ptw_core
// Input register, walk state and the single-pass step logic that turns one
// request word into at most one result word.
// ----------------------------------------------------------------------------
module ptw_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ptw_req_if.sink           i_req,
    ptw_cfg_if.sink           i_cfg,
    input  logic              i_res_ready,
    output logic              o_res_valid,
    output ptw_pkg::t_res     o_res
);

    logic                         r_in_vld;
    ptw_pkg::t_req                r_in;
    logic                         r_busy;
    logic                         n_busy;
    logic [ptw_pkg::LVL_W-1:0]    r_level;
    logic [ptw_pkg::LVL_W-1:0]    n_level;
    logic [ptw_pkg::ADDR_W-1:0]   r_vaddr;
    logic [ptw_pkg::ADDR_W-1:0]   n_vaddr;
    logic [ptw_pkg::ADDR_W-1:0]   r_root;
    logic                         adv;
    logic                         desc_zero;
    logic [ptw_pkg::ADDR_W-1:0]   page;

    // input stage frees up whenever the result side can take a word
    assign adv         = r_in_vld && i_res_ready;
    assign i_req.ready = !r_in_vld || i_res_ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    // input payload
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in.req_type   <= i_req.req_type;
            r_in.virt_addr  <= i_req.virt_addr;
            r_in.descriptor <= i_req.descriptor;
        end
    end

    // root table register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root <= ptw_pkg::ROOT_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_root <= i_cfg.wdata;
        end
    end

    assign desc_zero = (r_in.descriptor == '0);
    assign page      = r_in.descriptor[ptw_pkg::ADDR_W-1:0] & ptw_pkg::BASE_MASK;

    // one walk step
    always_comb begin
        n_busy      = r_busy;
        n_level     = r_level;
        n_vaddr     = r_vaddr;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (adv) begin
            if (r_in.req_type == ptw_pkg::REQ_XLATE) begin
                // start over at the root, dropping any walk in flight
                n_busy          = 1'b1;
                n_level         = ptw_pkg::LVL_TOP;
                n_vaddr         = r_in.virt_addr;
                o_res_valid     = 1'b1;
                o_res.out_kind  = ptw_pkg::KIND_READ;
                o_res.read_addr = ptw_pkg::entry_addr(r_root, r_in.virt_addr,
                                                      ptw_pkg::LVL_TOP);
            end else if (r_busy) begin
                o_res_valid = 1'b1;
                if (desc_zero) begin
                    n_busy         = 1'b0;
                    o_res.out_kind = ptw_pkg::KIND_DONE;
                    o_res.fault    = 1'b1;
                end else if (r_level == ptw_pkg::LVL_LAST) begin
                    n_busy          = 1'b0;
                    o_res.out_kind  = ptw_pkg::KIND_DONE;
                    o_res.phys_addr = page
                                    | {{(ptw_pkg::ADDR_W - ptw_pkg::PG_BITS){1'b0}},
                                       r_vaddr[ptw_pkg::PG_BITS-1:0]};
                    o_res.page_end  = {1'b0, page} + ptw_pkg::PG_SIZE;
                end else begin
                    n_level         = r_level - 1'b1;
                    o_res.out_kind  = ptw_pkg::KIND_READ;
                    o_res.read_addr = ptw_pkg::entry_addr(page, r_vaddr,
                                                          r_level - 1'b1);
                end
            end
        end
    end

    // walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_level <= '0;
            r_vaddr <= '0;
        end else begin
            r_busy  <= n_busy;
            r_level <= n_level;
            r_vaddr <= n_vaddr;
        end
    end

`ifndef SYNTHESIS
    // a processed translate request leaves the walker busy at the top level
    a_start_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_in.req_type == ptw_pkg::REQ_XLATE
        |=> r_busy && r_level == ptw_pkg::LVL_TOP)
        else $error("walk did not start at the top level");

    // a response while idle yields no word
    a_idle_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_in.req_type == ptw_pkg::REQ_DESC && !r_busy |-> !o_res_valid)
        else $error("response while idle produced a word");
`endif

endmodule

>>> design/ptw_res_fifo.sv
// ----------------------------------------------------------------------------
// ptw_res_fifo
// Two-entry result queue; its ready comes from a register so the stall on
// the result side never reaches the request side in the same cycle.
// ----------------------------------------------------------------------------
module ptw_res_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ptw_pkg::t_res     i_data,
    output logic              o_ready,
    ptw_res_if.source         o_res
);

    ptw_pkg::t_res   r_mem [2];
    logic            r_wptr;
    logic            r_rptr;
    logic [1:0]      r_count;
    logic            pop;
    ptw_pkg::t_res   head;

    assign o_ready = (r_count != 2'd2);
    assign pop     = o_res.valid && o_res.ready;
    assign head    = r_mem[r_rptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(pop);
        end
    end

    // head word to the port
    assign o_res.valid     = (r_count != 2'd0);
    assign o_res.out_kind  = head.out_kind;
    assign o_res.read_addr = head.read_addr;
    assign o_res.phys_addr = head.phys_addr;
    assign o_res.page_end  = head.page_end;
    assign o_res.fault     = head.fault;

`ifndef SYNTHESIS
    // the core never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_count != 2'd2)
        else $error("result pushed while queue full");

    // fill count stays within depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("result queue count out of range");
`endif

endmodule

>>> design/four_level_page_table_walker_unit.sv
// ----------------------------------------------------------------------------
// four_level_page_table_walker_unit
// Four-level, 4 KB granule page table walker for 48-bit virtual addresses.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      word
//  i_req    in   valid/ready    req_type, virt_addr, descriptor
//  o_res    out  valid/ready    out_kind, read_addr, phys_addr, page_end, fault
//  i_cfg    in   valid/ready    wdata (root table address)
//
//  one word per cycle sustained while o_res does not stall; each word is held in
//  the input register, then its result is written into a two-entry queue
//  reset is synchronous and active low; root table address resets to 4096
//  a stall on o_res fills the queue, then holds the input register; i_req
//  keeps its ready until both are full, with no combinational path between
// ----------------------------------------------------------------------------
module four_level_page_table_walker_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ptw_req_if.sink   i_req,
    ptw_cfg_if.sink   i_cfg,
    ptw_res_if.source o_res
);

    logic            res_valid;
    logic            res_ready;
    ptw_pkg::t_res   res_data;

    // step logic and walk state
    ptw_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg       (i_cfg),
        .i_res_ready (res_ready),
        .o_res_valid (res_valid),
        .o_res       (res_data)
    );

    // result queue
    ptw_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res_data),
        .o_ready (res_ready),
        .o_res   (o_res)
    );

endmodule
